[src/lpsd_pkg.sv]
// ----------------------------------------------------------------------------
// LED PWM plane shift driver package
// Field widths, command codes, controller states and the command and status
// bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
package lpsd_pkg;

   localparam int NUM_BANKS_DEF      = 5;
   localparam int LEDS_PER_BANK_DEF  = 10;
   localparam int MAX_PLANES_DEF     = 64;
   localparam int BITS_PER_CHAIN_DEF = 32;

   localparam int CMD_W     = 1;
   localparam int LED_IDX_W = 6;
   localparam int LEVEL_W   = 7;
   localparam int LANE_W    = 5;
   localparam int PLANE_W   = 6;

   localparam logic [CMD_W-1:0] CMD_WRITE   = 1'b0;
   localparam logic [CMD_W-1:0] CMD_REFRESH = 1'b1;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SHIFT
   } lpsd_state_type;

   typedef struct packed {
      logic write;
      logic load;
      logic step;
   } lpsd_ctl_type;

   typedef struct packed {
      logic step_last;
      logic out_free;
   } lpsd_sts_type;

endpackage

[src/lpsd_ifs.sv]
// ----------------------------------------------------------------------------
// LED PWM plane shift driver channels
// Request channel (colour writes and refresh ticks) and response channel
// (one serial bit step per item), both valid/ready.
// ----------------------------------------------------------------------------
interface lpsd_req_if;
   logic                          valid;
   logic                          ready;
   logic [lpsd_pkg::CMD_W-1:0]     cmd;
   logic [lpsd_pkg::LED_IDX_W-1:0] led_index;
   logic [lpsd_pkg::LEVEL_W-1:0]   red;
   logic [lpsd_pkg::LEVEL_W-1:0]   green;
   logic [lpsd_pkg::LEVEL_W-1:0]   blue;

   modport source (output valid, cmd, led_index, red, green, blue, input ready);
   modport sink   (input valid, cmd, led_index, red, green, blue, output ready);
endinterface

interface lpsd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lpsd_pkg::LANE_W-1:0]  lane_bits;
   logic [lpsd_pkg::PLANE_W-1:0] plane;
   logic                        latch;
   logic                        last;

   modport source (output valid, lane_bits, plane, latch, last, input ready);
   modport sink   (input valid, lane_bits, plane, latch, last, output ready);
endinterface

[src/lpsd_ctrl.sv]
// ----------------------------------------------------------------------------
// LED PWM plane shift driver controller
// Accepts requests while idle and sequences the bit steps of a refresh.
// ----------------------------------------------------------------------------
module lpsd_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [lpsd_pkg::CMD_W-1:0] req_cmd,
   output logic                       req_ready,
   input  lpsd_pkg::lpsd_sts_type     sts,
   output lpsd_pkg::lpsd_ctl_type     ctl
);
   import lpsd_pkg::*;

   lpsd_state_type state_ff;
   lpsd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_cmd == CMD_REFRESH)) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            if (sts.out_free && sts.step_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      ctl       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctl.write = req_valid && (req_cmd == CMD_WRITE);
            ctl.load  = req_valid && (req_cmd == CMD_REFRESH);
         end
         ST_SHIFT: begin
            ctl.step = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

[src/lpsd_datapath.sv]
// ----------------------------------------------------------------------------
// LED PWM plane shift driver datapath
// Per-bank colour store, chain position counters, plane counter, plane
// count register and the response output register.
// ----------------------------------------------------------------------------
module lpsd_datapath #(
   parameter int NUM_BANKS      = lpsd_pkg::NUM_BANKS_DEF,
   parameter int LEDS_PER_BANK  = lpsd_pkg::LEDS_PER_BANK_DEF,
   parameter int MAX_PLANES     = lpsd_pkg::MAX_PLANES_DEF,
   parameter int BITS_PER_CHAIN = lpsd_pkg::BITS_PER_CHAIN_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  lpsd_pkg::lpsd_ctl_type         ctl,
   output lpsd_pkg::lpsd_sts_type         sts,
   input  logic                           csr_valid,
   input  logic [lpsd_pkg::LEVEL_W-1:0]   csr_wdata,
   input  logic [lpsd_pkg::LED_IDX_W-1:0] wr_led_index,
   input  logic [lpsd_pkg::LEVEL_W-1:0]   wr_red,
   input  logic [lpsd_pkg::LEVEL_W-1:0]   wr_green,
   input  logic [lpsd_pkg::LEVEL_W-1:0]   wr_blue,
   input  logic                           rsp_ready,
   output logic                           rsp_valid,
   output logic [lpsd_pkg::LANE_W-1:0]    rsp_lane_bits,
   output logic [lpsd_pkg::PLANE_W-1:0]   rsp_plane,
   output logic                           rsp_last
);
   import lpsd_pkg::*;

   localparam int AW         = (LEDS_PER_BANK > 1) ? $clog2(LEDS_PER_BANK) : 1;
   localparam int SW         = $clog2(BITS_PER_CHAIN);
   localparam int QN         = (BITS_PER_CHAIN / 8) * 8;
   localparam int Q_TOP      = QN - 1;
   localparam int SLOT_START = Q_TOP / 3;
   localparam int COL_START  = Q_TOP % 3;
   localparam int SLOT_W0    = $clog2(SLOT_START + 1);
   localparam int SLOT_W     = (SLOT_W0 > AW) ? SLOT_W0 : AW;
   localparam int PW         = $clog2(MAX_PLANES);
   localparam int ENTRY_W    = 3 * LEVEL_W;

   logic [SW-1:0]      step_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [1:0]         colour_ff;
   logic [PW-1:0]      plane_ff;
   logic [LEVEL_W-1:0] plane_count_ff;
   logic               out_valid_ff;
   logic [LANE_W-1:0]  lanes_ff;
   logic [PW-1:0]      out_plane_ff;
   logic               out_last_ff;

   logic               q_valid;
   logic               slot_ok;
   logic [LANE_W-1:0]  lane_bit;
   logic [ENTRY_W-1:0] wr_entry;
   logic [LEVEL_W-1:0] limit;
   logic [LEVEL_W-1:0] plane_inc;
   logic [PW-1:0]      plane_in;

   function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
      logic [LEVEL_W-1:0] top;
      top = LEVEL_W'(MAX_PLANES);
      return (v > top) ? top : v;
   endfunction

   assign wr_entry = {sat_level(wr_blue), sat_level(wr_green), sat_level(wr_red)};
   assign q_valid  = ({1'b0, step_ff} < (SW+1)'(QN));
   assign slot_ok  = ({1'b0, slot_ff} < (SLOT_W+1)'(LEDS_PER_BANK));

   for (genvar j = 0; j < LANE_W; j++) begin : g_lane
      if (j < NUM_BANKS) begin : g_bank
         localparam int LO = j * LEDS_PER_BANK;
         logic [ENTRY_W-1:0] mem_ff [LEDS_PER_BANK];
         logic               hit;
         logic [AW-1:0]      wslot;
         logic [ENTRY_W-1:0] entry;
         logic [LEVEL_W-1:0] level;

         assign hit   = ({1'b0, wr_led_index} >= (LED_IDX_W+1)'(LO)) &&
                        ({1'b0, wr_led_index} < (LED_IDX_W+1)'(LO + LEDS_PER_BANK));
         assign wslot = AW'(wr_led_index - LED_IDX_W'(LO));
         assign entry = mem_ff[slot_ff[AW-1:0]];

         always_ff @(posedge clock) begin
            if (reset) begin
               for (int i = 0; i < LEDS_PER_BANK; i++) begin
                  mem_ff[i] <= '0;
               end
            end else if (ctl.write && hit) begin
               mem_ff[wslot] <= wr_entry;
            end
         end

         always_comb begin
            case (colour_ff)
               2'd0:    level = entry[LEVEL_W-1:0];
               2'd1:    level = entry[2*LEVEL_W-1:LEVEL_W];
               2'd2:    level = entry[3*LEVEL_W-1:2*LEVEL_W];
               default: level = '0;
            endcase
         end

         assign lane_bit[j] = q_valid && slot_ok && (LEVEL_W'(plane_ff) < level);
      end else begin : g_none
         assign lane_bit[j] = 1'b0;
      end
   end

   always_comb begin
      if (plane_count_ff == '0) begin
         limit = LEVEL_W'(1);
      end else if (plane_count_ff > LEVEL_W'(MAX_PLANES)) begin
         limit = LEVEL_W'(MAX_PLANES);
      end else begin
         limit = plane_count_ff;
      end
      plane_inc = LEVEL_W'(plane_ff) + LEVEL_W'(1);
      plane_in  = (plane_inc >= limit) ? '0 : plane_inc[PW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff        <= '0;
         slot_ff        <= '0;
         colour_ff      <= '0;
         plane_ff       <= '0;
         plane_count_ff <= LEVEL_W'(MAX_PLANES);
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            plane_count_ff <= csr_wdata;
         end
         if (ctl.load) begin
            step_ff   <= '0;
            slot_ff   <= SLOT_W'(SLOT_START);
            colour_ff <= 2'(COL_START);
         end else if (ctl.step) begin
            step_ff <= step_ff + SW'(1);
            if (colour_ff == 2'd0) begin
               colour_ff <= 2'd2;
               slot_ff   <= slot_ff - SLOT_W'(1);
            end else begin
               colour_ff <= colour_ff - 2'd1;
            end
            if (sts.step_last) begin
               plane_ff <= plane_in;
            end
         end
         if (ctl.step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         lanes_ff     <= lane_bit;
         out_plane_ff <= plane_ff;
         out_last_ff  <= sts.step_last;
      end
   end

   assign sts.step_last = (step_ff == SW'(BITS_PER_CHAIN - 1));
   assign sts.out_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid     = out_valid_ff;
   assign rsp_lane_bits = lanes_ff;
   assign rsp_plane     = PLANE_W'(out_plane_ff);
   assign rsp_last      = out_last_ff;

endmodule

[src/led_pwm_plane_shift_driver.sv]
// ----------------------------------------------------------------------------
// LED PWM plane shift driver
// Stores RGB levels per LED and shifts one PWM bit plane per refresh tick
// to every bank's serial chain, one bit step per response item.
//
//   channel  dir  signals                                   notes
//   req_ch   in   valid ready cmd led_index red green blue  write or refresh
//   rsp_ch   out  valid ready lane_bits plane latch last    one bit step
//   csr      in   csr_valid csr_ready csr_wdata             plane_count
//
// A refresh tick is a load, then BITS_PER_CHAIN steps at one per cycle out
// of the step counter into the response register; a stalled response holds
// the step sequence.
// Reset clears the colour store at once, zeroes the plane counter and sets
// plane_count to MAX_PLANES. csr_ready is always high.
// ----------------------------------------------------------------------------
module led_pwm_plane_shift_driver #(
   parameter int NUM_BANKS      = lpsd_pkg::NUM_BANKS_DEF,
   parameter int LEDS_PER_BANK  = lpsd_pkg::LEDS_PER_BANK_DEF,
   parameter int MAX_PLANES     = lpsd_pkg::MAX_PLANES_DEF,
   parameter int BITS_PER_CHAIN = lpsd_pkg::BITS_PER_CHAIN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   lpsd_req_if.sink                     req_ch,
   lpsd_rsp_if.source                   rsp_ch,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [lpsd_pkg::LEVEL_W-1:0] csr_wdata
);
   import lpsd_pkg::*;

   lpsd_ctl_type ctl;
   lpsd_sts_type sts;
   logic         rsp_last;

   assign csr_ready = 1'b1;

   lpsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   lpsd_datapath #(
      .NUM_BANKS      (NUM_BANKS),
      .LEDS_PER_BANK  (LEDS_PER_BANK),
      .MAX_PLANES     (MAX_PLANES),
      .BITS_PER_CHAIN (BITS_PER_CHAIN)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .sts           (sts),
      .csr_valid     (csr_valid && csr_ready),
      .csr_wdata     (csr_wdata),
      .wr_led_index  (req_ch.led_index),
      .wr_red        (req_ch.red),
      .wr_green      (req_ch.green),
      .wr_blue       (req_ch.blue),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_lane_bits (rsp_ch.lane_bits),
      .rsp_plane     (rsp_ch.plane),
      .rsp_last      (rsp_last)
   );

   assign rsp_ch.last  = rsp_last;
   assign rsp_ch.latch = rsp_last;

`ifndef SYNTH
   a_refresh_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (req_ch.valid && req_ch.ready && (req_ch.cmd == CMD_REFRESH)) |=> !req_ch.ready)
      else $error("request taken during refresh");

   a_last_step_out: assert property (@(posedge clock) disable iff (reset)
      (ctl.step && sts.step_last) |=> (rsp_ch.valid && rsp_ch.last))
      else $error("final step not presented");

   a_step_excl: assert property (@(posedge clock) disable iff (reset)
      ctl.step |-> (!ctl.write && !ctl.load && !req_ch.ready))
      else $error("step overlaps request");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// LED PWM plane shift driver testbench
// Drives colour writes and refresh ticks with random gaps and response
// stalls, and checks every serial bit step against an in-bench model of the
// colour store and plane counter. It starts with a directed table, then runs
// random phases under several plane_count settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import lpsd_pkg::*;

   localparam int BANKS = NUM_BANKS_DEF;
   localparam int SLOTS = LEDS_PER_BANK_DEF;
   localparam int LEDS  = BANKS * SLOTS;
   localparam int STEPS = BITS_PER_CHAIN_DEF;

   typedef struct packed {
      logic [CMD_W-1:0]     cmd;
      logic [LED_IDX_W-1:0] led_index;
      logic [LEVEL_W-1:0]   red;
      logic [LEVEL_W-1:0]   green;
      logic [LEVEL_W-1:0]   blue;
      logic                 typed;
      logic [PLANE_W-1:0]   t_plane;
      logic [LANE_W-1:0]    t_lanes;
      logic [STEPS-1:0]     t_steps;
   } stim_row_t;

   typedef struct packed {
      logic [LANE_W-1:0]  lanes;
      logic [PLANE_W-1:0] plane;
      logic               latch;
      logic               last;
   } bit_step_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_valid;
   logic               csr_ready;
   logic [LEVEL_W-1:0] csr_wdata;

   lpsd_req_if req_bus ();
   lpsd_rsp_if rsp_bus ();

   led_pwm_plane_shift_driver uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [LEVEL_W-1:0] led_level [LEDS][3];
   logic [PLANE_W-1:0] cur_plane;
   logic [LEVEL_W-1:0] plane_count_reg;
   bit_step_t          step_q [$];
   int                 err_count = 0;
   bit                 steady_flow = 1'b0;

   task automatic flag_error(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      err_count++;
   endtask

   function automatic logic [LEVEL_W-1:0] clamp_level(logic [LEVEL_W-1:0] v);
      return (v > MAX_PLANES_DEF) ? LEVEL_W'(MAX_PLANES_DEF) : v;
   endfunction

   function automatic bit_step_t chain_step(int s);
      bit_step_t st;
      int        byte_no;
      int        q;
      int        slot;
      int        colour;
      byte_no = STEPS / 8 - 1 - s / 8;
      q       = byte_no * 8 + 7 - s % 8;
      slot    = q / 3;
      colour  = q % 3;
      st      = '0;
      if (slot < SLOTS) begin
         for (int j = 0; j < BANKS; j++)
            st.lanes[j] = (cur_plane < led_level[j * SLOTS + slot][colour]);
      end
      st.plane = cur_plane;
      st.latch = (s == STEPS - 1);
      st.last  = (s == STEPS - 1);
      return st;
   endfunction

   function automatic void advance_plane();
      int lim;
      if (plane_count_reg == 0)
         lim = 1;
      else if (plane_count_reg > MAX_PLANES_DEF)
         lim = MAX_PLANES_DEF;
      else
         lim = plane_count_reg;
      cur_plane = (int'(cur_plane) + 1 >= lim) ? '0 : cur_plane + 1'b1;
   endfunction

   function automatic void account_item(stim_row_t r);
      bit_step_t st;
      if (r.cmd == CMD_WRITE) begin
         if (r.led_index < LEDS) begin
            led_level[r.led_index][0] = clamp_level(r.red);
            led_level[r.led_index][1] = clamp_level(r.green);
            led_level[r.led_index][2] = clamp_level(r.blue);
         end
      end else begin
         for (int s = 0; s < STEPS; s++) begin
            if (r.typed) begin
               st.lanes = r.t_steps[s] ? r.t_lanes : '0;
               st.plane = r.t_plane;
               st.latch = (s == STEPS - 1);
               st.last  = (s == STEPS - 1);
            end else begin
               st = chain_step(s);
            end
            step_q.push_back(st);
         end
         advance_plane();
      end
   endfunction

   function automatic logic [LEVEL_W-1:0] random_level();
      case ($urandom_range(0, 7))
         0: return LEVEL_W'($urandom_range(65, 127));
         1: return $urandom_range(0, 1) ? LEVEL_W'(64) : LEVEL_W'(0);
         default: return LEVEL_W'($urandom_range(0, 64));
      endcase
   endfunction

   function automatic stim_row_t random_item();
      stim_row_t r;
      r           = '0;
      r.cmd       = $urandom_range(0, 1) ? CMD_REFRESH : CMD_WRITE;
      r.led_index = ($urandom_range(0, 9) == 0) ? LED_IDX_W'($urandom_range(50, 63))
                                                : LED_IDX_W'($urandom_range(0, 49));
      r.red       = random_level();
      r.green     = random_level();
      r.blue      = random_level();
      return r;
   endfunction

   task automatic send_item(stim_row_t r);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= r.cmd;
      req_bus.led_index <= r.led_index;
      req_bus.red       <= r.red;
      req_bus.green     <= r.green;
      req_bus.blue      <= r.blue;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      account_item(r);
   endtask

   task automatic set_plane_count(logic [LEVEL_W-1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid       <= 1'b0;
      plane_count_reg = v;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (step_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // response side stalls
   initial begin
      int hold;
      rsp_bus.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, 11);
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   always @(posedge clock) begin
      bit_step_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (step_q.size() == 0) begin
            flag_error($sformatf("unexpected step lanes=%b plane=%0d",
                                 rsp_bus.lane_bits, rsp_bus.plane));
         end else begin
            want = step_q.pop_front();
            if (rsp_bus.lane_bits !== want.lanes)
               flag_error($sformatf("lane_bits got %b want %b",
                                    rsp_bus.lane_bits, want.lanes));
            if (rsp_bus.plane !== want.plane)
               flag_error($sformatf("plane got %0d want %0d", rsp_bus.plane, want.plane));
            if (rsp_bus.latch !== want.latch)
               flag_error($sformatf("latch got %b want %b", rsp_bus.latch, want.latch));
            if (rsp_bus.last !== want.last)
               flag_error($sformatf("last got %b want %b", rsp_bus.last, want.last));
         end
      end
   end

   initial begin
      stim_row_t          rows [15];
      logic [LEVEL_W-1:0] counts [9];

      rows = '{
         '{CMD_REFRESH, 6'd0,  7'd0,   7'd0,   7'd0,   1'b1, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd0,  7'd64,  7'd0,   7'd0,   1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd40, 7'd64,  7'd0,   7'd0,   1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd50, 7'd127, 7'd127, 7'd127, 1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd63, 7'd127, 7'd127, 7'd127, 1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_REFRESH, 6'd0,  7'd0,   7'd0,   7'd0,   1'b1, 6'd1, 5'b10001,
           32'h8000_0000},
         '{CMD_WRITE,   6'd9,  7'd0,   7'd0,   7'd127, 1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd49, 7'd0,   7'd127, 7'd0,   1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd25, 7'd1,   7'd1,   7'd1,   1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd33, 7'd63,  7'd64,  7'd65,  1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd17, 7'd127, 7'd0,   7'd64,  1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_REFRESH, 6'd0,  7'd0,   7'd0,   7'd0,   1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd0,  7'd0,   7'd0,   7'd0,   1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_WRITE,   6'd40, 7'd0,   7'd0,   7'd0,   1'b0, 6'd0, 5'b00000, 32'h0},
         '{CMD_REFRESH, 6'd0,  7'd0,   7'd0,   7'd0,   1'b0, 6'd0, 5'b00000, 32'h0}
      };
      counts = '{7'd64, 7'd5, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd0, 7'd0};
      counts[7] = LEVEL_W'($urandom_range(1, 64));
      counts[8] = LEVEL_W'($urandom_range(0, 127));

      req_bus.valid     <= 1'b0;
      req_bus.cmd       <= CMD_WRITE;
      req_bus.led_index <= '0;
      req_bus.red       <= '0;
      req_bus.green     <= '0;
      req_bus.blue      <= '0;
      csr_valid         <= 1'b0;
      csr_wdata         <= '0;
      cur_plane         = '0;
      plane_count_reg   = LEVEL_W'(MAX_PLANES_DEF);
      foreach (led_level[i, c])
         led_level[i][c] = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (rows[i])
         send_item(rows[i]);

      for (int ph = 0; ph < 9; ph++) begin
         drain();
         set_plane_count(counts[ph]);
         steady_flow = (ph % 3 == 1);
         repeat (11) send_item(random_item());
      end
      drain();
      steady_flow = 1'b0;
      repeat (40) @(posedge clock);

      if (err_count == 0)
         $display("** led_pwm_plane_shift_driver: PASSED **");
      else
         $display("** led_pwm_plane_shift_driver: FAILED **");
      $finish;
   end

   initial begin
      #5ms;
      $display("** led_pwm_plane_shift_driver: FAILED **");
      $finish;
   end

endmodule

[sim.f]
src/lpsd_pkg.sv
src/lpsd_ifs.sv
src/lpsd_ctrl.sv
src/lpsd_datapath.sv
src/led_pwm_plane_shift_driver.sv
tb/tb_top.sv
